### rtl/rfsp_pkg.sv
`timescale 1ns / 1ps

package rfsp_pkg;

    // ring depth and the widths that follow from it
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int STAT_W = 32;

    // request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // bit v set when v is prime, v in 0..255
    localparam logic [255:0] PRIME_BITS = {
        32'h08028228, 32'h800800A2, 32'h80282088, 32'h20A00A08,
        32'h800228A2, 32'h02088288, 32'h28208A20, 32'hA08A28AC
    };

    function automatic logic prime_lookup(input logic [7:0] v);
        return PRIME_BITS[v];
    endfunction

endpackage

### rtl/rfsp_ctrl.sv
`timescale 1ns / 1ps

module rfsp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output rfsp_pkg::ctrl_cmd_t cmd
);

    rfsp_pkg::state_t state_reg;
    rfsp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfsp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rfsp_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = rfsp_pkg::S_EXEC;
                end
            end
            rfsp_pkg::S_EXEC: begin
                state_next = rfsp_pkg::S_RESP;
            end
            rfsp_pkg::S_RESP: begin
                if (m_ready) begin
                    state_next = rfsp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rfsp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            rfsp_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            rfsp_pkg::S_EXEC: begin
                cmd.execute = 1'b1;
            end
            rfsp_pkg::S_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/rfsp_dp.sv
`timescale 1ns / 1ps

module rfsp_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rfsp_pkg::ctrl_cmd_t           cmd,
    input  logic                          s_command,
    input  logic [7:0]                    s_item_value,
    output logic [1:0]                    m_status,
    output logic [7:0]                    m_removed_value,
    output logic                          m_removed_is_prime,
    output logic [3:0]                    m_occupancy,
    output logic [rfsp_pkg::STAT_W-1:0]   m_produced_count,
    output logic [rfsp_pkg::STAT_W-1:0]   m_consumed_count,
    output logic [rfsp_pkg::STAT_W-1:0]   m_full_events,
    output logic [rfsp_pkg::STAT_W-1:0]   m_empty_events
);

    localparam logic [rfsp_pkg::IDX_W-1:0] LAST_IDX = rfsp_pkg::IDX_W'(rfsp_pkg::DEPTH - 1);
    localparam logic [rfsp_pkg::CNT_W-1:0] FULL_CNT = rfsp_pkg::CNT_W'(rfsp_pkg::DEPTH);

    logic [7:0] slot_mem [rfsp_pkg::DEPTH];
    logic [7:0] rd_data_reg;

    logic                        req_cmd_reg;
    logic [7:0]                  req_value_reg;
    logic [rfsp_pkg::IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [rfsp_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [rfsp_pkg::CNT_W-1:0]  held_reg, held_next;
    logic [rfsp_pkg::STAT_W-1:0] produced_reg, produced_next;
    logic [rfsp_pkg::STAT_W-1:0] consumed_reg, consumed_next;
    logic [rfsp_pkg::STAT_W-1:0] full_ev_reg, full_ev_next;
    logic [rfsp_pkg::STAT_W-1:0] empty_ev_reg, empty_ev_next;
    rfsp_pkg::status_t           status_reg, status_next;
    logic [7:0]                  removed_reg, removed_next;
    logic                        prime_reg, prime_next;
    logic                        do_write;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_cmd_reg   <= s_command;
            req_value_reg <= s_item_value;
        end
    end

    // slot store, read address is the head of the ring
    always_ff @(posedge aclk) begin
        if (do_write) begin
            slot_mem[wr_idx_reg] <= req_value_reg;
        end
        rd_data_reg <= slot_mem[rd_idx_reg];
    end

    always_comb begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        held_next     = held_reg;
        produced_next = produced_reg;
        consumed_next = consumed_reg;
        full_ev_next  = full_ev_reg;
        empty_ev_next = empty_ev_reg;
        status_next   = rfsp_pkg::STAT_DONE;
        removed_next  = 8'd0;
        prime_next    = 1'b0;
        do_write      = 1'b0;
        if (req_cmd_reg == rfsp_pkg::CMD_INSERT) begin
            if (held_reg == FULL_CNT) begin
                status_next = rfsp_pkg::STAT_FULL;
            end else begin
                do_write      = cmd.execute;
                wr_idx_next   = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                held_next     = held_reg + 1'b1;
                produced_next = produced_reg + 1'b1;
                if (held_next == FULL_CNT) begin
                    full_ev_next = full_ev_reg + 1'b1;
                end
            end
        end else begin
            if (held_reg == '0) begin
                status_next = rfsp_pkg::STAT_EMPTY;
            end else begin
                removed_next  = rd_data_reg;
                prime_next    = rfsp_pkg::prime_lookup(rd_data_reg);
                rd_idx_next   = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                held_next     = held_reg - 1'b1;
                consumed_next = consumed_reg + 1'b1;
                if (held_next == '0) begin
                    empty_ev_next = empty_ev_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            held_reg     <= '0;
            produced_reg <= '0;
            consumed_reg <= '0;
            full_ev_reg  <= '0;
            empty_ev_reg <= '0;
        end else if (cmd.execute) begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            held_reg     <= held_next;
            produced_reg <= produced_next;
            consumed_reg <= consumed_next;
            full_ev_reg  <= full_ev_next;
            empty_ev_reg <= empty_ev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            prime_reg   <= prime_next;
        end
    end

    assign m_status           = status_reg;
    assign m_removed_value    = removed_reg;
    assign m_removed_is_prime = prime_reg;
    assign m_occupancy        = 4'(held_reg);
    assign m_produced_count   = produced_reg;
    assign m_consumed_count   = consumed_reg;
    assign m_full_events      = full_ev_reg;
    assign m_empty_events     = empty_ev_reg;

endmodule

### rtl/ring_fifo_with_stats_and_prime_flag.sv
`timescale 1ns / 1ps

// channel   | direction | beat contents
// ----------+-----------+---------------------------------------------------
// s_        | in        | command, item_value
// m_        | out       | status, removed_value, removed_is_prime, occupancy,
//           |           | produced_count, consumed_count, full_events, empty_events
//
// one request at a time: a beat is taken in the idle state, executed the next
// cycle, and its result offered the cycle after; the ring's registered read
// port sets the execute step
// aresetn (synchronous) clears indices, fill count and statistics, not the slots
// a stalled result holds the block in its response state until m_ready

module ring_fifo_with_stats_and_prime_flag (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request beat
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [7:0]                          s_item_value,
    // result beat
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [7:0]                          m_removed_value,
    output logic                                m_removed_is_prime,
    output logic [3:0]                          m_occupancy,
    output logic [rfsp_pkg::STAT_W-1:0]         m_produced_count,
    output logic [rfsp_pkg::STAT_W-1:0]         m_consumed_count,
    output logic [rfsp_pkg::STAT_W-1:0]         m_full_events,
    output logic [rfsp_pkg::STAT_W-1:0]         m_empty_events
);

    // controller to datapath commands
    rfsp_pkg::ctrl_cmd_t cmd;

    // sequencing and handshakes
    rfsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // ring storage, indices, statistics and prime lookup
    rfsp_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_command          (s_command),
        .s_item_value       (s_item_value),
        .m_status           (m_status),
        .m_removed_value    (m_removed_value),
        .m_removed_is_prime (m_removed_is_prime),
        .m_occupancy        (m_occupancy),
        .m_produced_count   (m_produced_count),
        .m_consumed_count   (m_consumed_count),
        .m_full_events      (m_full_events),
        .m_empty_events     (m_empty_events)
    );

endmodule
